[sv/gbn_pkg.sv]
`timescale 1ns / 1ps
// gbn_pkg: shared types and constants of the go-back-N sender window.
// No dependencies; used by the channel interfaces, the wait FIFO and the top level.
package gbn_pkg;

	localparam int CMD_W = 2;
	localparam int REF_W = 16;
	localparam int LEN_W = 11;
	localparam int SEQ_W = 32;
	localparam int CFG_W = 4;

	// command codes on the request channel
	localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ACK     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NAK     = 2'd3;

	// window size after reset
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 4'd4;

	// frame descriptor: buffer handle and length
	typedef struct packed {
		logic [REF_W-1:0] handle;
		logic [LEN_W-1:0] len;
	} desc_t;

	// wait FIFO status toward the sequencer
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

[sv/gbn_req_if.sv]
`timescale 1ns / 1ps
// gbn_req_if: request channel (send, timeout, ack, nak) with valid/ready.
// Depends on gbn_pkg for field widths.
interface gbn_req_if;
	logic                      valid;
	logic                      ready;
	logic [gbn_pkg::CMD_W-1:0] cmd;
	logic [gbn_pkg::REF_W-1:0] frame_ref;
	logic [gbn_pkg::LEN_W-1:0] frame_len;
	logic [gbn_pkg::SEQ_W-1:0] seq_num;

	modport source (output valid, cmd, frame_ref, frame_len, seq_num, input ready);
	modport sink   (input valid, cmd, frame_ref, frame_len, seq_num, output ready);
endinterface

[sv/gbn_tx_if.sv]
`timescale 1ns / 1ps
// gbn_tx_if: transmit channel, one frame descriptor and sequence number per word.
// Depends on gbn_pkg for field widths.
interface gbn_tx_if;
	logic                      valid;
	logic                      ready;
	logic [gbn_pkg::REF_W-1:0] tx_ref;
	logic [gbn_pkg::LEN_W-1:0] tx_len;
	logic [gbn_pkg::SEQ_W-1:0] tx_seq;
	logic                      last;

	modport source (output valid, tx_ref, tx_len, tx_seq, last, input ready);
	modport sink   (input valid, tx_ref, tx_len, tx_seq, last, output ready);
endinterface

[sv/gbn_wait_fifo.sv]
`timescale 1ns / 1ps
// gbn_wait_fifo: bounded FIFO of frame descriptors waiting for window space.
// Depends on gbn_pkg (desc_t, fifo_stat_t). Read data is registered on pop.
module gbn_wait_fifo #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gbn_pkg::desc_t     push_data,
	input  logic               pop,
	output gbn_pkg::desc_t     pop_data,
	output gbn_pkg::fifo_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	gbn_pkg::desc_t mem [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));

	// storage: one write and one registered read port
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (pop) begin
			pop_data <= mem[rd_ptr_q];
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/go_back_n_sender_window.sv]
`timescale 1ns / 1ps
// Go-back-N sender window. A request is taken only while the sequencer is idle.
// Every request is taken in the idle state and then goes through the window compare. An ack,
// timeout or nak whose number lies outside the window ends there. A send goes on to the send
// state, whether it goes out, waits or is dropped.
// A timeout or nak that hits the window retransmits from that number to the end of the window.
// Each refilled or retransmitted frame goes through a registered read of the window store or
// wait FIFO and then a state that loads the output word. An ack that hits first slides the
// window in a state of its own, then refills from the wait FIFO. Transmit ready low stalls every
// state that loads the output word. A single 32-bit adder/subtractor is shared for the window
// compare, the base update and every transmitted sequence number. The output word register lets
// a new request be taken while the last word of the previous one still waits.
// Depends on gbn_pkg, gbn_req_if, gbn_tx_if and gbn_wait_fifo.
module go_back_n_sender_window #(
	parameter int WINDOW_MAX = 8,
	parameter int WAIT_DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [gbn_pkg::CFG_W-1:0] cfg_wdata,
	gbn_req_if.sink                   req,
	gbn_tx_if.source                  tx
);

	localparam int OW = $clog2(WINDOW_MAX + 1);
	localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_SEND, S_ACK, S_FILL_RD, S_FILL_EMIT, S_RETX_RD, S_RETX_EMIT
	} state_t;

	state_t                     state_q;
	logic [gbn_pkg::CMD_W-1:0]  cmd_q;
	gbn_pkg::desc_t             desc_q;
	logic [gbn_pkg::SEQ_W-1:0]  seq_q;
	logic [gbn_pkg::CFG_W-1:0]  wsize_q;
	logic [gbn_pkg::SEQ_W-1:0]  base_q;
	logic [OW-1:0]              outst_q;
	logic [OW-1:0]              off_q;
	logic [OW-1:0]              idx_q;
	logic [SW-1:0]              head_q;
	logic                       out_valid_q;
	gbn_pkg::desc_t             out_desc_q;
	logic [gbn_pkg::SEQ_W-1:0]  out_seq_q;
	logic                       out_last_q;

	gbn_pkg::desc_t             win_mem [WINDOW_MAX];
	gbn_pkg::desc_t             win_rd_q;

	// wrap head + offset into the window store, offset at most WINDOW_MAX
	function automatic logic [SW-1:0] slot_wrap(input logic [SW-1:0] h, input logic [7:0] x);
		logic [7:0] s;
		s = 8'(h) + x;
		if (s >= 8'(WINDOW_MAX)) begin
			s = s - 8'(WINDOW_MAX);
		end
		return s[SW-1:0];
	endfunction

	// effective window: 0 acts as 1, clamp at WINDOW_MAX
	logic [7:0] win8;
	logic [7:0] outst8;
	always_comb begin
		if (wsize_q == '0) begin
			win8 = 8'd1;
		end else if (8'(wsize_q) > 8'(WINDOW_MAX)) begin
			win8 = 8'(WINDOW_MAX);
		end else begin
			win8 = 8'(wsize_q);
		end
	end
	assign outst8 = 8'(outst_q);

	// shared 32-bit adder/subtractor
	logic [gbn_pkg::SEQ_W-1:0] add_a;
	logic [gbn_pkg::SEQ_W-1:0] add_b;
	logic                      add_sub;
	logic [gbn_pkg::SEQ_W-1:0] add_res;
	always_comb begin
		add_a   = base_q;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			S_DECODE: begin
				add_a   = seq_q;
				add_b   = base_q;
				add_sub = 1'b1;
			end
			S_ACK: begin
				add_a = seq_q;
				add_b = gbn_pkg::SEQ_W'(1);
			end
			S_SEND, S_FILL_EMIT: begin
				add_b = gbn_pkg::SEQ_W'(outst_q);
			end
			S_RETX_EMIT: begin
				add_b = gbn_pkg::SEQ_W'(idx_q);
			end
			default: begin
				add_b = '0;
			end
		endcase
	end
	assign add_res = add_a + (add_b ^ {gbn_pkg::SEQ_W{add_sub}})
		+ gbn_pkg::SEQ_W'(add_sub);

	// window hit: offset from base below the outstanding count
	logic hit;
	assign hit = (add_res < gbn_pkg::SEQ_W'(outst_q));

	// wait FIFO
	gbn_pkg::desc_t      fifo_rd;
	gbn_pkg::fifo_stat_t fifo_stat;
	logic                fifo_push;
	logic                fifo_pop;
	logic                room;

	assign room      = (outst8 < win8);
	assign fifo_push = (state_q == S_SEND) && !room && !fifo_stat.full;
	assign fifo_pop  = (state_q == S_FILL_RD) && room && !fifo_stat.empty;

	gbn_wait_fifo #(
		.DEPTH(WAIT_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fifo_push),
		.push_data(desc_q),
		.pop      (fifo_pop),
		.pop_data (fifo_rd),
		.stat     (fifo_stat)
	);

	// output word slot free this cycle
	logic out_free;
	assign out_free = !out_valid_q || tx.ready;

	// a new output word is loaded this cycle
	logic tx_load;
	assign tx_load = out_free && ((state_q == S_SEND && room) || state_q == S_FILL_EMIT
		|| state_q == S_RETX_EMIT);

	// window store ports
	logic          win_we;
	logic [SW-1:0] win_wr_slot;
	logic [SW-1:0] win_rd_slot;
	gbn_pkg::desc_t win_wdata;

	assign win_wr_slot = slot_wrap(head_q, outst8);
	assign win_rd_slot = slot_wrap(head_q, 8'(idx_q));
	assign win_we      = out_free && ((state_q == S_SEND && room) || state_q == S_FILL_EMIT);
	assign win_wdata   = (state_q == S_FILL_EMIT) ? fifo_rd : desc_q;

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_wr_slot] <= win_wdata;
		end
		win_rd_q <= win_mem[win_rd_slot];
	end

	// refill continues after this word
	logic fill_more;
	assign fill_more = ((outst8 + 8'd1) < win8) && !fifo_stat.empty;

	// sequencer, window state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= gbn_pkg::CMD_SEND;
			desc_q      <= '0;
			seq_q       <= '0;
			wsize_q     <= gbn_pkg::WINDOW_SIZE_RESET;
			base_q      <= '0;
			outst_q     <= '0;
			off_q       <= '0;
			idx_q       <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
			out_desc_q  <= '0;
			out_seq_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				wsize_q <= cfg_wdata;
			end
			out_valid_q <= tx_load || (out_valid_q && !tx.ready);
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q       <= req.cmd;
						desc_q      <= '{handle: req.frame_ref, len: req.frame_len};
						seq_q       <= req.seq_num;
						state_q     <= S_DECODE;
					end
				end
				S_DECODE: begin
					off_q <= add_res[OW-1:0];
					idx_q <= add_res[OW-1:0];
					case (cmd_q)
						gbn_pkg::CMD_SEND: state_q <= S_SEND;
						gbn_pkg::CMD_ACK:  state_q <= hit ? S_ACK : S_IDLE;
						default:           state_q <= hit ? S_RETX_RD : S_IDLE;
					endcase
				end
				S_SEND: begin
					if (!room) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_desc_q  <= desc_q;
						out_seq_q   <= add_res;
						out_last_q  <= 1'b1;
						outst_q     <= outst_q + OW'(1);
						state_q     <= S_IDLE;
					end
				end
				S_ACK: begin
					base_q  <= add_res;
					head_q  <= slot_wrap(head_q, 8'(off_q) + 8'd1);
					outst_q <= outst_q - off_q - OW'(1);
					state_q <= S_FILL_RD;
				end
				S_FILL_RD: begin
					state_q <= fifo_pop ? S_FILL_EMIT : S_IDLE;
				end
				S_FILL_EMIT: begin
					if (out_free) begin
						out_desc_q  <= fifo_rd;
						out_seq_q   <= add_res;
						out_last_q  <= !fill_more;
						outst_q     <= outst_q + OW'(1);
						state_q     <= fill_more ? S_FILL_RD : S_IDLE;
					end
				end
				S_RETX_RD: begin
					state_q <= S_RETX_EMIT;
				end
				S_RETX_EMIT: begin
					if (out_free) begin
						out_desc_q  <= win_rd_q;
						out_seq_q   <= add_res;
						out_last_q  <= (idx_q + OW'(1) == outst_q);
						idx_q       <= idx_q + OW'(1);
						state_q     <= (idx_q + OW'(1) == outst_q) ? S_IDLE : S_RETX_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign tx.valid  = out_valid_q;
	assign tx.tx_ref = out_desc_q.handle;
	assign tx.tx_len = out_desc_q.len;
	assign tx.tx_seq = out_seq_q;
	assign tx.last   = out_last_q;

endmodule

[sv/gbn_checker.sv]
`timescale 1ns / 1ps
// gbn_checker: port-level checks of the go-back-N sender window, bound to the top level.
// Depends on gbn_pkg for field widths.
module gbn_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [gbn_pkg::REF_W-1:0] out_ref,
	input logic [gbn_pkg::LEN_W-1:0] out_len,
	input logic [gbn_pkg::SEQ_W-1:0] out_seq,
	input logic                      out_last
);

	// a stalled word stays put
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_ref) && $stable(out_len)
			&& $stable(out_seq) && $stable(out_last))
		else $error("transmit word changed while stalled");

	// one request at a time: busy right after a request is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while sequencer busy");

	// more words of the current request pending: no new request
	a_no_take_midburst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("ready while a burst is unfinished");

	// a pending word at request time closes the previous burst
	a_pending_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid |-> out_last)
		else $error("request taken before previous burst ended");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (req.valid),
	.in_ready (req.ready),
	.out_valid(tx.valid),
	.out_ready(tx.ready),
	.out_ref  (tx.tx_ref),
	.out_len  (tx.tx_len),
	.out_seq  (tx.tx_seq),
	.out_last (tx.last)
);
